[src/lcf_pkg.sv]
// ----------------------------------------------------------------------------
// lcf_pkg
// Types and constants shared by the linear convolution FIR block.
// ----------------------------------------------------------------------------
package lcf_pkg;

	localparam int VAL_W    = 16;  // Q1.15 sample / coefficient
	localparam int IDX_W    = 5;   // coefficient index
	localparam int CNT_W    = 6;   // tap count and tap counters
	localparam int PROD_W   = 32;  // Q2.30 product
	localparam int RES_W    = 40;  // Q10.30 accumulator
	localparam int TAPS_DEF = 32;  // default delay line / coefficient depth
	localparam int N_MAX    = 32;  // most taps one output may use

	localparam logic [CNT_W-1:0] TAP_COUNT_RST = CNT_W'(29);

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_LOAD   = 1'b1;

	typedef struct packed {
		logic                    op;
		logic [IDX_W-1:0]        coef_index;
		logic signed [VAL_W-1:0] value;
		logic                    last;
	} item_t;

	typedef struct packed {
		logic signed [RES_W-1:0] result;
		logic                    last_res;
	} res_t;

	// taps in use: register value limited to 1..lim
	function automatic logic [CNT_W-1:0] clamp_taps(input logic [CNT_W-1:0] tc,
			input logic [CNT_W-1:0] lim);
		logic [CNT_W-1:0] n;
		n = tc;
		if (n == '0) begin
			n = CNT_W'(1);
		end
		if (n > lim) begin
			n = lim;
		end
		return n;
	endfunction

endpackage

[src/lcf_ram.sv]
// ----------------------------------------------------------------------------
// lcf_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lcf_ram #(
	parameter int WIDTH = lcf_pkg::VAL_W,
	parameter int DEPTH = lcf_pkg::TAPS_DEF
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[src/linear_convolution_fir.sv]
// ----------------------------------------------------------------------------
// linear_convolution_fir
// Direct-form FIR computing the full linear convolution of a sample stream
// with a loaded impulse response, using one shared multiply-accumulate.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid / item_ready / item): op = OP_LOAD writes one
//   Q1.15 coefficient at coef_index (ignored unless below TAPS) and gives no
//   result. op = OP_SAMPLE pushes value into the delay line and yields one
//   Q10.30 sum of products on the res channel (res_valid / res_ready / res).
//   A sample with last set also yields n-1 tail results computed with zero
//   input, the final one flagged last_res, and then clears the delay line.
//   n is tap_count (cfg_we / cfg_wdata) limited to 1..min(TAPS,32), sampled
//   when the sample is accepted; write it only while the block is idle.
// Dataflow:
//   For each result the delay line and coefficient RAMs are read once per tap
//   into a single 16x16 multiplier, followed by the RAM read data, product and
//   accumulator registers and then the output register. A sample is accepted
//   again in the cycle after its last result is loaded.
// Reset and stall:
//   Reset clears tap_count to 29 and marks both stores empty (read as zero).
//   The output register holds a result until it is taken; the next item is
//   accepted meanwhile, and a further result waits until the register frees.
// ----------------------------------------------------------------------------
module linear_convolution_fir #(
	parameter int TAPS = lcf_pkg::TAPS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_ready,
	input  lcf_pkg::item_t             item,
	output logic                       res_valid,
	input  logic                       res_ready,
	output lcf_pkg::res_t              res,
	input  logic                       cfg_we,
	input  logic [lcf_pkg::CNT_W-1:0]  cfg_wdata
);

	localparam int AW  = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam int LIM = (TAPS < lcf_pkg::N_MAX) ? TAPS : lcf_pkg::N_MAX;
	localparam logic [lcf_pkg::CNT_W-1:0] N_LIM  = lcf_pkg::CNT_W'(LIM);
	localparam logic [AW-1:0]             A_LAST = AW'(TAPS - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MAC  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]                    state_q;
	logic [lcf_pkg::CNT_W-1:0]     tap_count_q;
	logic [lcf_pkg::CNT_W-1:0]     n_q;
	logic [lcf_pkg::CNT_W-1:0]     tail_q;
	logic [lcf_pkg::CNT_W-1:0]     j_q;
	logic                          last_q;
	logic [AW-1:0]                 wp_q;
	logic [AW-1:0]                 rp_q;
	logic [TAPS-1:0]               cvld_q;
	logic [TAPS-1:0]               dvld_q;

	logic                          tap_s1;
	logic                          cvld_s1;
	logic                          dvld_s1;
	logic                          tap_s2;
	logic signed [lcf_pkg::PROD_W-1:0] prod_s2;
	logic signed [lcf_pkg::RES_W-1:0]  acc_q;

	lcf_pkg::res_t                 res_q;
	logic                          res_valid_q;

	logic [lcf_pkg::VAL_W-1:0]     coef_rd;
	logic [lcf_pkg::VAL_W-1:0]     dl_rd;
	logic signed [lcf_pkg::VAL_W-1:0] coef_m;
	logic signed [lcf_pkg::VAL_W-1:0] dl_m;

	logic                          accept;
	logic                          is_load;
	logic                          sample_go;
	logic                          load_wr;
	logic [lcf_pkg::CNT_W-1:0]     n_cur;
	logic [AW-1:0]                 wp_nx;
	logic [AW-1:0]                 rp_nx;
	logic [AW-1:0]                 coef_raddr;
	logic [AW-1:0]                 coef_waddr;
	logic                          pipe_empty;
	logic                          out_free;
	logic                          push;
	logic                          tail_go;
	logic                          dl_we;
	logic [lcf_pkg::VAL_W-1:0]     dl_wdata;

	assign item_ready = (state_q == ST_IDLE);
	assign accept     = item_valid && item_ready;
	assign is_load    = (item.op == lcf_pkg::OP_LOAD);
	assign sample_go  = accept && !is_load;
	assign load_wr    = accept && is_load && (int'(item.coef_index) < TAPS);
	assign coef_waddr = AW'(item.coef_index);
	assign n_cur      = lcf_pkg::clamp_taps(tap_count_q, N_LIM);

	// circular delay line: newest sample at wp_q, older ones at decreasing addresses
	assign wp_nx      = (wp_q == A_LAST) ? '0 : wp_q + AW'(1);
	assign rp_nx      = (rp_q == '0) ? A_LAST : rp_q - AW'(1);
	assign coef_raddr = j_q[AW-1:0];

	assign pipe_empty = !tap_s1 && !tap_s2;
	assign out_free   = !res_valid_q || res_ready;
	assign push       = (state_q == ST_FIN) && pipe_empty && out_free;
	assign tail_go    = push && (tail_q != '0);

	assign dl_we      = sample_go || tail_go;
	assign dl_wdata   = sample_go ? item.value : '0;

	lcf_ram #(
		.WIDTH (lcf_pkg::VAL_W),
		.DEPTH (TAPS)
	) u_coef_ram (
		.clk   (clk),
		.we    (load_wr),
		.waddr (coef_waddr),
		.wdata (item.value),
		.raddr (coef_raddr),
		.rdata (coef_rd)
	);

	lcf_ram #(
		.WIDTH (lcf_pkg::VAL_W),
		.DEPTH (TAPS)
	) u_dl_ram (
		.clk   (clk),
		.we    (dl_we),
		.waddr (wp_nx),
		.wdata (dl_wdata),
		.raddr (rp_q),
		.rdata (dl_rd)
	);

	// entries never written since reset, and delay line entries since the last flush, read as zero
	assign coef_m = cvld_s1 ? $signed(coef_rd) : '0;
	assign dl_m   = dvld_s1 ? $signed(dl_rd) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= lcf_pkg::TAP_COUNT_RST;
		end else if (cfg_we) begin
			tap_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q     <= lcf_pkg::CNT_W'(1);
			tail_q  <= '0;
			j_q     <= '0;
			last_q  <= 1'b0;
			wp_q    <= '0;
			rp_q    <= '0;
			cvld_q  <= '0;
			dvld_q  <= '0;
		end else begin
			if (load_wr) begin
				cvld_q[coef_waddr] <= 1'b1;
			end
			if (dl_we) begin
				dvld_q[wp_nx] <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (sample_go) begin
						n_q     <= n_cur;
						last_q  <= item.last;
						tail_q  <= item.last ? n_cur - lcf_pkg::CNT_W'(1) : '0;
						wp_q    <= wp_nx;
						rp_q    <= wp_nx;
						j_q     <= '0;
						state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					if (j_q == n_q - lcf_pkg::CNT_W'(1)) begin
						state_q <= ST_FIN;
					end else begin
						j_q  <= j_q + lcf_pkg::CNT_W'(1);
						rp_q <= rp_nx;
					end
				end
				ST_FIN: begin
					if (tail_go) begin
						// zero shifted in for the next tail output
						tail_q  <= tail_q - lcf_pkg::CNT_W'(1);
						wp_q    <= wp_nx;
						rp_q    <= wp_nx;
						j_q     <= '0;
						state_q <= ST_MAC;
					end else if (push) begin
						if (last_q) begin
							dvld_q <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// read issue -> multiply -> accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_s1  <= 1'b0;
			cvld_s1 <= 1'b0;
			dvld_s1 <= 1'b0;
			tap_s2  <= 1'b0;
		end else begin
			tap_s1  <= (state_q == ST_MAC);
			cvld_s1 <= cvld_q[coef_raddr];
			dvld_s1 <= dvld_q[rp_q];
			tap_s2  <= tap_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= coef_m * dl_m;
		if (sample_go || tail_go) begin
			acc_q <= '0;
		end else if (tap_s2) begin
			acc_q <= acc_q + lcf_pkg::RES_W'(prod_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (push) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			res_q.result   <= acc_q;
			res_q.last_res <= last_q && (tail_q == '0);
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_j_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MAC) |-> (j_q < n_q))
		else $error("tap counter ran past taps in use");

	a_n_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> ((n_q != '0) && (n_q <= N_LIM) && (tail_q < n_q)))
		else $error("tap or tail count out of range");

	a_pipe_order: assert property (@(posedge clk) disable iff (!arst_n)
		tap_s2 |-> $past(tap_s1))
		else $error("multiply stage without a read issue");

	a_push_empty: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!tap_s1 && !tap_s2 && (state_q == ST_FIN)))
		else $error("result transfer before accumulation finished");

	a_flush_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !tail_go && last_q) |=> (dvld_q == '0))
		else $error("delay line not cleared after final output");

endmodule
